[sv/cple_pkg.sv]
// Shared types and constants for the circular positional list engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package cple_pkg;

    // Default sizing of the element store
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the item fields
    localparam int FUNC_W  = 3;
    localparam int ITEM_W  = 32;
    localparam int POS_W   = 7;
    localparam int COUNT_W = 7;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        F_INS_HEAD = 3'd0,
        F_INS_TAIL = 3'd1,
        F_INS_POS  = 3'd2,
        F_DEL_HEAD = 3'd3,
        F_DEL_TAIL = 3'd4,
        F_DEL_POS  = 3'd5,
        F_COUNT    = 3'd6,
        F_DUMP     = 3'd7
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // Where a new entry goes once it is taken from the free chain
    typedef enum logic [1:0] {
        IK_HEAD = 2'd0,
        IK_TAIL = 2'd1,
        IK_MID  = 2'd2
    } ins_kind_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_TAKE_RD,
        S_TAKE_WB,
        S_MID_WR,
        S_LINK2,
        S_DH_RD,
        S_DH_WB,
        S_GIVE,
        S_DT_WB,
        S_DM_RD1,
        S_DM_RD2,
        S_DM_WB,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_RESP
    } state_t;

    // One operation request
    typedef struct packed {
        func_t                     func;
        logic signed [ITEM_W-1:0]  item_value;
        logic [POS_W-1:0]          position;
    } req_t;

    // One result
    typedef struct packed {
        status_t                   status;
        logic [COUNT_W-1:0]        element_count;
        logic signed [ITEM_W-1:0]  element_value;
        logic                      last_result;
    } rsp_t;

endpackage

`default_nettype wire

[sv/cple_store.sv]
// Link and value memories of the list engine, one read port shared by both.
// Depends on cple_pkg. Link entries never written read as the initial free chain.
`default_nettype none

module cple_store
    import cple_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          link_we,
    input  wire logic [$clog2(CAPACITY)-1:0]   link_waddr,
    input  wire logic [$clog2(CAPACITY)-1:0]   link_wdata,
    input  wire logic                          val_we,
    input  wire logic [$clog2(CAPACITY)-1:0]   val_waddr,
    input  wire logic [DATA_WIDTH-1:0]         val_wdata,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(CAPACITY)-1:0]   rd_addr,
    output logic      [$clog2(CAPACITY)-1:0]   link_rdata,
    output logic      [DATA_WIDTH-1:0]         val_rdata
);

    localparam int AW = $clog2(CAPACITY);

    logic [AW-1:0]         link_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] val_mem  [CAPACITY];
    logic [CAPACITY-1:0]   link_valid_reg;
    logic [AW-1:0]         link_rdata_reg;
    logic [DATA_WIDTH-1:0] val_rdata_reg;
    logic [AW-1:0]         chain_init;

    // Initial free chain: entry i links to i+1, the last wraps to zero
    assign chain_init = (rd_addr == AW'(CAPACITY - 1)) ? '0 : AW'(rd_addr + 1'b1);

    // Mark link entries as written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_valid_reg <= '0;
        end
        else if (link_we)
        begin
            link_valid_reg[link_waddr] <= 1'b1;
        end
    end

    // Write both memories and register the read data
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        if (rd_en)
        begin
            link_rdata_reg <= link_valid_reg[rd_addr] ? link_mem[rd_addr] : chain_init;
            val_rdata_reg  <= val_mem[rd_addr];
        end
    end

    assign link_rdata = link_rdata_reg;
    assign val_rdata  = val_rdata_reg;

endmodule

`default_nettype wire

[sv/circular_positional_list_engine.sv]
// Mid-list positional ops and multi-element tail deletes walk the link memory one entry a cycle.
// Dump: reads the head first, then one element a cycle while results are taken.
// One item at a time; the walk over the single link read port sets the worst case.
// Reset clears control state and the link-written flags at once; no clearing pass.
// Top level of the circular positional list engine; depends on cple_pkg and cple_store.
`default_nettype none

module circular_positional_list_engine
    import cple_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int SW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((SW > POS_W) ? SW : POS_W) + 1;

    state_t                state_reg, state_next;
    state_t                post_reg, post_next;
    ins_kind_t             kind_reg, kind_next;
    status_t               status_reg, status_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [AW-1:0]         tail_reg, tail_next;
    logic [AW-1:0]         free_reg, free_next;
    logic [SW-1:0]         size_reg, size_next;
    logic [AW-1:0]         cur_reg, cur_next;
    logic                  pend_reg, pend_next;
    logic [SW-1:0]         cnt_reg, cnt_next;
    logic [AW-1:0]         node_reg, node_next;
    logic [AW-1:0]         wa2_reg, wa2_next;
    logic [AW-1:0]         wd2_reg, wd2_next;
    logic                  out_valid_reg, out_valid_next;
    rsp_t                  out_reg, out_next;

    // Memory port controls
    logic                  link_we;
    logic [AW-1:0]         link_waddr;
    logic [AW-1:0]         link_wdata;
    logic                  val_we;
    logic [AW-1:0]         val_waddr;
    logic [DATA_WIDTH-1:0] val_wdata;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         link_rd;
    logic [DATA_WIDTH-1:0] val_rd;

    // Decode results
    state_t                dec_next;
    state_t                dec_post;
    ins_kind_t             dec_kind;
    status_t               dec_status;
    logic [SW-1:0]         dec_steps;

    logic [CMPW-1:0]       pos_x;
    logic [CMPW-1:0]       size_x;
    logic                  is_full;
    logic                  is_empty;
    logic                  is_single;
    logic                  ins_bad;
    logic                  del_bad;
    logic                  out_free;
    logic [AW-1:0]         p_now;

    cple_store #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .val_we     (val_we),
        .val_waddr  (val_waddr),
        .val_wdata  (val_wdata),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .link_rdata (link_rd),
        .val_rdata  (val_rd)
    );

    // List shape and position checks
    assign pos_x     = CMPW'(req.position);
    assign size_x    = CMPW'(size_reg);
    assign is_full   = (size_reg == SW'(CAPACITY));
    assign is_empty  = (size_reg == '0);
    assign is_single = (size_reg == SW'(1));
    assign ins_bad   = (pos_x == '0) || (pos_x > CMPW'(size_x + 1'b1));
    assign del_bad   = (pos_x == '0) || (pos_x > size_x);
    assign out_free  = !out_valid_reg || rsp_ready;
    assign p_now     = pend_reg ? link_rd : cur_reg;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Decode the incoming operation into a plan
    always_comb
    begin
        dec_next   = S_RESP;
        dec_post   = S_IDLE;
        dec_kind   = IK_HEAD;
        dec_status = ST_DONE;
        dec_steps  = '0;
        case (req.func)
            F_INS_HEAD, F_INS_TAIL:
            begin
                if (is_full)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_next = S_TAKE_RD;
                    dec_kind = (req.func == F_INS_HEAD) ? IK_HEAD : IK_TAIL;
                end
            end
            F_INS_POS:
            begin
                if (ins_bad)
                begin
                    dec_status = ST_BAD;
                end
                else if (is_full)
                begin
                    dec_status = ST_FULL;
                end
                else if (pos_x == CMPW'(1))
                begin
                    dec_next = S_TAKE_RD;
                    dec_kind = IK_HEAD;
                end
                else if (pos_x == CMPW'(size_x + 1'b1))
                begin
                    dec_next = S_TAKE_RD;
                    dec_kind = IK_TAIL;
                end
                else
                begin
                    dec_next  = S_WALK;
                    dec_post  = S_TAKE_RD;
                    dec_kind  = IK_MID;
                    dec_steps = SW'(pos_x - CMPW'(2));
                end
            end
            F_DEL_HEAD:
            begin
                if (is_empty)
                begin
                    dec_status = ST_BAD;
                end
                else if (is_single)
                begin
                    dec_next = S_GIVE;
                end
                else
                begin
                    dec_next = S_DH_RD;
                end
            end
            F_DEL_TAIL:
            begin
                if (is_empty)
                begin
                    dec_status = ST_BAD;
                end
                else if (is_single)
                begin
                    dec_next = S_GIVE;
                end
                else
                begin
                    dec_next  = S_WALK;
                    dec_post  = S_DT_WB;
                    dec_steps = SW'(size_x - CMPW'(2));
                end
            end
            F_DEL_POS:
            begin
                if (del_bad)
                begin
                    dec_status = ST_BAD;
                end
                else if (is_single)
                begin
                    dec_next = S_GIVE;
                end
                else if (pos_x == CMPW'(1))
                begin
                    dec_next = S_DH_RD;
                end
                else if (pos_x == size_x)
                begin
                    dec_next  = S_WALK;
                    dec_post  = S_DT_WB;
                    dec_steps = SW'(size_x - CMPW'(2));
                end
                else
                begin
                    dec_next  = S_WALK;
                    dec_post  = S_DM_RD1;
                    dec_steps = SW'(pos_x - CMPW'(2));
                end
            end
            F_COUNT:
            begin
                dec_status = ST_DONE;
            end
            F_DUMP:
            begin
                if (is_empty)
                begin
                    dec_status = ST_BAD;
                end
                else
                begin
                    dec_next = S_DUMP_RD;
                end
            end
            default:
            begin
                dec_status = ST_DONE;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = dec_next;
                end
            end
            S_WALK:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = post_reg;
                end
            end
            S_TAKE_RD:  state_next = S_TAKE_WB;
            S_TAKE_WB:
            begin
                if (is_empty)
                begin
                    state_next = S_RESP;
                end
                else if (kind_reg == IK_MID)
                begin
                    state_next = S_MID_WR;
                end
                else
                begin
                    state_next = S_LINK2;
                end
            end
            S_MID_WR:   state_next = S_LINK2;
            S_LINK2:    state_next = S_RESP;
            S_DH_RD:    state_next = S_DH_WB;
            S_DH_WB:    state_next = S_LINK2;
            S_GIVE:     state_next = S_RESP;
            S_DT_WB:    state_next = S_LINK2;
            S_DM_RD1:   state_next = S_DM_RD2;
            S_DM_RD2:   state_next = S_DM_WB;
            S_DM_WB:    state_next = S_LINK2;
            S_DUMP_RD:  state_next = S_DUMP_OUT;
            S_DUMP_OUT:
            begin
                if (out_free && (cnt_reg == SW'(1)))
                begin
                    state_next = S_IDLE;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath, memory accesses and result register
    always_comb
    begin
        post_next      = post_reg;
        kind_next      = kind_reg;
        status_next    = status_reg;
        val_next       = val_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_next      = free_reg;
        size_next      = size_reg;
        cur_next       = cur_reg;
        pend_next      = pend_reg;
        cnt_next       = cnt_reg;
        node_next      = node_reg;
        wa2_next       = wa2_reg;
        wd2_next       = wd2_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        link_we        = 1'b0;
        link_waddr     = '0;
        link_wdata     = '0;
        val_we         = 1'b0;
        val_waddr      = '0;
        val_wdata      = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        case (state_reg)
            S_IDLE:
            begin
                // Latch the plan for the accepted item
                if (req_valid)
                begin
                    post_next   = dec_post;
                    kind_next   = dec_kind;
                    status_next = dec_status;
                    cnt_next    = dec_steps;
                    cur_next    = head_reg;
                    pend_next   = 1'b0;
                    val_next    = DATA_WIDTH'(req.item_value);
                end
            end
            S_WALK:
            begin
                // Chase one link a cycle; cur ends on the predecessor
                cur_next = p_now;
                if (cnt_reg != '0)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = p_now;
                    pend_next = 1'b1;
                    cnt_next  = SW'(cnt_reg - 1'b1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            S_TAKE_RD:
            begin
                // Fetch the free chain successor and store the new value
                rd_en     = 1'b1;
                rd_addr   = free_reg;
                val_we    = 1'b1;
                val_waddr = free_reg;
                val_wdata = val_reg;
            end
            S_TAKE_WB:
            begin
                free_next = link_rd;
                node_next = free_reg;
                size_next = SW'(size_reg + 1'b1);
                if (is_empty)
                begin
                    link_we    = 1'b1;
                    link_waddr = free_reg;
                    link_wdata = free_reg;
                    head_next  = free_reg;
                    tail_next  = free_reg;
                end
                else
                begin
                    case (kind_reg)
                        IK_HEAD:
                        begin
                            link_we    = 1'b1;
                            link_waddr = free_reg;
                            link_wdata = head_reg;
                            head_next  = free_reg;
                            wa2_next   = tail_reg;
                            wd2_next   = free_reg;
                        end
                        IK_TAIL:
                        begin
                            link_we    = 1'b1;
                            link_waddr = tail_reg;
                            link_wdata = free_reg;
                            tail_next  = free_reg;
                            wa2_next   = free_reg;
                            wd2_next   = head_reg;
                        end
                        IK_MID:
                        begin
                            rd_en   = 1'b1;
                            rd_addr = cur_reg;
                        end
                        default:
                        begin
                            rd_en = 1'b0;
                        end
                    endcase
                end
            end
            S_MID_WR:
            begin
                // Splice the new entry after the predecessor
                link_we    = 1'b1;
                link_waddr = node_reg;
                link_wdata = link_rd;
                wa2_next   = cur_reg;
                wd2_next   = node_reg;
            end
            S_LINK2:
            begin
                link_we    = 1'b1;
                link_waddr = wa2_reg;
                link_wdata = wd2_reg;
            end
            S_DH_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = head_reg;
            end
            S_DH_WB:
            begin
                // Advance the head, close the ring and free the old head
                head_next  = link_rd;
                link_we    = 1'b1;
                link_waddr = tail_reg;
                link_wdata = link_rd;
                wa2_next   = head_reg;
                wd2_next   = free_reg;
                free_next  = head_reg;
                size_next  = SW'(size_reg - 1'b1);
            end
            S_GIVE:
            begin
                // Drop the only element
                link_we    = 1'b1;
                link_waddr = head_reg;
                link_wdata = free_reg;
                free_next  = head_reg;
                head_next  = '0;
                tail_next  = '0;
                size_next  = '0;
            end
            S_DT_WB:
            begin
                // Predecessor becomes the tail, old tail goes to the free chain
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = head_reg;
                wa2_next   = tail_reg;
                wd2_next   = free_reg;
                free_next  = tail_reg;
                tail_next  = cur_reg;
                size_next  = SW'(size_reg - 1'b1);
            end
            S_DM_RD1:
            begin
                rd_en   = 1'b1;
                rd_addr = cur_reg;
            end
            S_DM_RD2:
            begin
                node_next = link_rd;
                rd_en     = 1'b1;
                rd_addr   = link_rd;
            end
            S_DM_WB:
            begin
                // Unlink the target and free it
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = link_rd;
                wa2_next   = node_reg;
                wd2_next   = free_reg;
                free_next  = node_reg;
                size_next  = SW'(size_reg - 1'b1);
            end
            S_DUMP_RD:
            begin
                rd_en    = 1'b1;
                rd_addr  = head_reg;
                cnt_next = size_reg;
            end
            S_DUMP_OUT:
            begin
                // Emit one element and fetch the next while results drain
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.status        = ST_DONE;
                    out_next.element_count = COUNT_W'(size_reg);
                    out_next.element_value = ITEM_W'($signed(val_rd));
                    out_next.last_result   = (cnt_reg == SW'(1));
                    if (cnt_reg != SW'(1))
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = link_rd;
                        cnt_next = SW'(cnt_reg - 1'b1);
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.status        = status_reg;
                    out_next.element_count = COUNT_W'(size_reg);
                    out_next.element_value = '0;
                    out_next.last_result   = 1'b1;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            free_reg      <= '0;
            size_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_reg      <= free_next;
            size_reg      <= size_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        post_reg   <= post_next;
        kind_reg   <= kind_next;
        status_reg <= status_next;
        val_reg    <= val_next;
        cur_reg    <= cur_next;
        cnt_reg    <= cnt_next;
        node_reg   <= node_next;
        wa2_reg    <= wa2_next;
        wd2_reg    <= wd2_next;
        out_reg    <= out_next;
    end

endmodule

`default_nettype wire

[sv/cple_checker.sv]
// Port-level checks for the circular positional list engine, bound to the top level.
// Depends on cple_pkg.
`default_nettype none

module cple_checker
    import cple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire req_t req,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp
);

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // Drop ready after taking an item
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item taken while busy");

    // Bound the element count
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.element_count <= COUNT_W'(CAPACITY))
        else $error("element count above capacity");

    // Rejected operations give one zero-valued final result
    a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_DONE) |-> rsp.last_result && (rsp.element_value == '0))
        else $error("rejected result malformed");

    // A full rejection only happens at capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_FULL) |-> rsp.element_count == COUNT_W'(CAPACITY))
        else $error("full status below capacity");

endmodule

bind circular_positional_list_engine cple_checker #(.CAPACITY(CAPACITY)) u_cple_checker (.*);

`default_nettype wire
